FILE: hdl/asc_pkg.sv
// Package for the advertising signature classifier.
// Holds the class codes, the signature constants and the request record
// that the front part hands to the back part. Depends on nothing.
package asc_pkg;

	// Class codes delivered on the result channel.
	localparam logic [3:0] CLS_NONE       = 4'd0;
	localparam logic [3:0] CLS_CO_SUB02   = 4'd1;
	localparam logic [3:0] CLS_CO_SUB07   = 4'd2;
	localparam logic [3:0] CLS_CO_SUB0F   = 4'd3;
	localparam logic [3:0] CLS_CO_SUB12   = 4'd4;
	localparam logic [3:0] CLS_CO_OTHER   = 4'd5;
	localparam logic [3:0] CLS_CO06_PAT   = 4'd6;
	localparam logic [3:0] CLS_CO75       = 4'd7;
	localparam logic [3:0] CLS_SVC_FE2C   = 4'd8;
	localparam logic [3:0] CLS_SVC_ALT    = 4'd9;

	// Structure types and signatures.
	localparam logic [7:0]  AD_TYPE_MFG   = 8'hFF;
	localparam logic [7:0]  AD_TYPE_SVC   = 8'h16;
	localparam logic [15:0] CID_4C        = 16'h004C;
	localparam logic [15:0] CID_06        = 16'h0006;
	localparam logic [15:0] CID_75        = 16'h0075;
	localparam logic [7:0]  SUB_02        = 8'h02;
	localparam logic [7:0]  SUB_07        = 8'h07;
	localparam logic [7:0]  SUB_0F        = 8'h0F;
	localparam logic [7:0]  SUB_12        = 8'h12;
	localparam logic [7:0]  PAT06_B0      = 8'h03;
	localparam logic [7:0]  PAT06_B1      = 8'h00;
	localparam logic [7:0]  PAT06_B2      = 8'h80;
	localparam logic [15:0] UUID_FE2C     = 16'hFE2C;
	localparam logic [15:0] UUID_FEED     = 16'hFEED;
	localparam logic [15:0] UUID_FD84     = 16'hFD84;

	localparam int MFG_HEAD_LEN = 5;
	localparam int SVC_HEAD_LEN = 2;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Everything the back part needs to classify one advertisement.
	typedef struct packed {
		logic                             mfg_valid; // complete, payload at least 4
		logic                             mfg_long;  // payload at least 5
		logic [MFG_HEAD_LEN-1:0][7:0]     mfg_head;
		logic                             svc_valid; // complete, payload at least 2
		logic [SVC_HEAD_LEN-1:0][7:0]     svc_head;
	} asc_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} asc_qstat_t;

endpackage

FILE: hdl/adv_signature_classifier.sv
// Top level of the advertising signature classifier.
// Ties together asc_front, asc_queue and asc_back; depends on asc_pkg.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+---------------------
//   adv      | in        | adv_valid / adv_ready     | adv_byte, is_last
//   class    | out       | class_valid / class_ready | class_code
//
// One payload byte is accepted per cycle while the queue is not full. The
// front part walks the structures and, on the byte flagged is_last, pushes a
// classification request into a two-entry queue; the back part classifies
// the request at the queue head and loads the code into the output register.
// After reset the pointers, counts and flags are clear and the next byte
// starts a new advertisement.
// The byte stream stalls only when the queue is full, which happens only when
// two requests wait in the queue behind a code that the result side has not
// yet taken from the output register.
module adv_signature_classifier
	import asc_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv_valid,
	output logic       adv_ready,
	input  logic [7:0] adv_byte,
	input  logic       is_last,
	output logic       class_valid,
	input  logic       class_ready,
	output logic [3:0] class_code
);

	asc_req_t   wr_req, rd_req;
	asc_qstat_t qstat;
	logic       take, push, pop;

	// The front never waits on anything but queue space.
	assign adv_ready = !qstat.full;
	assign take      = adv_valid && adv_ready;

	asc_front #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.adv_byte (adv_byte),
		.is_last  (is_last),
		.push     (push),
		.req      (wr_req)
	);

	asc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_req (wr_req),
		.pop    (pop),
		.rd_req (rd_req),
		.stat   (qstat)
	);

	asc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.req         (rd_req),
		.pop         (pop),
		.class_valid (class_valid),
		.class_ready (class_ready),
		.class_code  (class_code)
	);

	// A delivered code is always one of the defined classes.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		class_valid |-> (class_code <= CLS_SVC_ALT))
		else $error("class code out of range");

	// The front must never push a request into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("request pushed into full queue");

	// A request pushed without a pop leaves the queue non-empty.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !qstat.empty)
		else $error("pushed request lost");

	// The back pops only when it can load its output register.
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!class_valid || class_ready))
		else $error("pop while output register blocked");

endmodule

FILE: hdl/asc_front.sv
// Front part of the advertising signature classifier: walks the structures
// byte by byte and captures the heads of the first matching structures.
// Depends on asc_pkg.
module asc_front
	import asc_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,       // byte accepted this cycle
	input  logic [7:0] adv_byte,
	input  logic       is_last,
	output logic       push,       // request for the queue
	output asc_req_t   req
);

	localparam logic [8:0] MAX9 = 9'(MAX_PAYLOAD_BYTES);

	logic [7:0] pos_q, nhp_q, len_q, mfg_len_q, svc_len_q;
	logic       stopped_q, cap_mfg_q, cap_svc_q, mfg_found_q, svc_found_q;
	logic [MFG_HEAD_LEN-1:0][7:0] mfg_head_q;
	logic [SVC_HEAD_LEN-1:0][7:0] svc_head_q;

	logic [7:0] pos_n, nhp_n, len_n, mfg_len_n, svc_len_n;
	logic       stopped_n, cap_mfg_n, cap_svc_n, mfg_found_n, svc_found_n;
	logic [MFG_HEAD_LEN-1:0][7:0] mfg_head_n;
	logic [SVC_HEAD_LEN-1:0][7:0] svc_head_n;

	logic [8:0] hdr_sum;
	logic [7:0] type_pos;
	logic [7:0] k;
	logic       in_range;
	logic       mfg_ok, svc_ok;

	always_comb begin
		pos_n       = pos_q;
		nhp_n       = nhp_q;
		len_n       = len_q;
		mfg_len_n   = mfg_len_q;
		svc_len_n   = svc_len_q;
		stopped_n   = stopped_q;
		cap_mfg_n   = cap_mfg_q;
		cap_svc_n   = cap_svc_q;
		mfg_found_n = mfg_found_q;
		svc_found_n = svc_found_q;
		mfg_head_n  = mfg_head_q;
		svc_head_n  = svc_head_q;

		in_range = ({1'b0, pos_q} < MAX9);
		hdr_sum  = {1'b0, pos_q} + 9'd1 + {1'b0, adv_byte};
		type_pos = nhp_q - len_q;
		k        = pos_q - type_pos - 8'd1;

		if (in_range) begin
			pos_n = pos_q + 8'd1;
			if (!stopped_q) begin
				if (pos_q == nhp_q) begin
					cap_mfg_n = 1'b0;
					cap_svc_n = 1'b0;
					if (adv_byte == 8'd0 || hdr_sum > MAX9) begin
						stopped_n = 1'b1;
					end else begin
						len_n = adv_byte;
						nhp_n = hdr_sum[7:0];
					end
				end else if (pos_q == type_pos) begin
					if (adv_byte == AD_TYPE_MFG && !mfg_found_q) begin
						mfg_found_n = 1'b1;
						cap_mfg_n   = 1'b1;
						mfg_len_n   = len_q - 8'd1;
					end else if (adv_byte == AD_TYPE_SVC && !svc_found_q) begin
						svc_found_n = 1'b1;
						cap_svc_n   = 1'b1;
						svc_len_n   = len_q - 8'd1;
					end
				end else begin
					if (cap_mfg_q && k < 8'(MFG_HEAD_LEN))
						mfg_head_n[k[2:0]] = adv_byte;
					if (cap_svc_q && k < 8'(SVC_HEAD_LEN))
						svc_head_n[k[0]] = adv_byte;
				end
			end
		end

		// A captured structure counts only once its last byte has arrived.
		mfg_ok = mfg_found_n && (!cap_mfg_n || nhp_n <= pos_n);
		svc_ok = svc_found_n && (!cap_svc_n || nhp_n <= pos_n);

		req.mfg_valid = mfg_ok && (mfg_len_n >= 8'd4);
		req.mfg_long  = (mfg_len_n >= 8'd5);
		req.mfg_head  = mfg_head_n;
		req.svc_valid = svc_ok && (svc_len_n >= 8'd2);
		req.svc_head  = svc_head_n;
	end

	assign push = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			nhp_q       <= '0;
			len_q       <= '0;
			mfg_len_q   <= '0;
			svc_len_q   <= '0;
			stopped_q   <= 1'b0;
			cap_mfg_q   <= 1'b0;
			cap_svc_q   <= 1'b0;
			mfg_found_q <= 1'b0;
			svc_found_q <= 1'b0;
			mfg_head_q  <= '0;
			svc_head_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				pos_q       <= '0;
				nhp_q       <= '0;
				len_q       <= '0;
				mfg_len_q   <= '0;
				svc_len_q   <= '0;
				stopped_q   <= 1'b0;
				cap_mfg_q   <= 1'b0;
				cap_svc_q   <= 1'b0;
				mfg_found_q <= 1'b0;
				svc_found_q <= 1'b0;
				mfg_head_q  <= '0;
				svc_head_q  <= '0;
			end else begin
				pos_q       <= pos_n;
				nhp_q       <= nhp_n;
				len_q       <= len_n;
				mfg_len_q   <= mfg_len_n;
				svc_len_q   <= svc_len_n;
				stopped_q   <= stopped_n;
				cap_mfg_q   <= cap_mfg_n;
				cap_svc_q   <= cap_svc_n;
				mfg_found_q <= mfg_found_n;
				svc_found_q <= svc_found_n;
				mfg_head_q  <= mfg_head_n;
				svc_head_q  <= svc_head_n;
			end
		end
	end

endmodule

FILE: hdl/asc_queue.sv
// Short request queue between the front and back parts of the classifier.
// Depends on asc_pkg.
module asc_queue
	import asc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  asc_req_t   wr_req,
	input  logic       pop,
	output asc_req_t   rd_req,
	output asc_qstat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	asc_req_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_req     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

FILE: hdl/asc_back.sv
// Back part of the classifier: turns a captured request into a class code
// and holds it in the output register. Depends on asc_pkg.
module asc_back
	import asc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  asc_qstat_t qstat,
	input  asc_req_t   req,
	output logic       pop,
	output logic       class_valid,
	input  logic       class_ready,
	output logic [3:0] class_code
);

	logic       valid_q;
	logic [3:0] code_q;
	logic [3:0] code_d;
	logic [15:0] cid, uuid;

	always_comb begin
		cid    = {req.mfg_head[1], req.mfg_head[0]};
		uuid   = {req.svc_head[1], req.svc_head[0]};
		code_d = CLS_NONE;
		if (req.mfg_valid && cid == CID_4C) begin
			case (req.mfg_head[2])
				SUB_02:  code_d = CLS_CO_SUB02;
				SUB_07:  code_d = CLS_CO_SUB07;
				SUB_0F:  code_d = CLS_CO_SUB0F;
				SUB_12:  code_d = CLS_CO_SUB12;
				default: code_d = CLS_CO_OTHER;
			endcase
		end else if (req.mfg_valid && cid == CID_06 && req.mfg_long &&
				req.mfg_head[2] == PAT06_B0 && req.mfg_head[3] == PAT06_B1 &&
				req.mfg_head[4] == PAT06_B2) begin
			code_d = CLS_CO06_PAT;
		end else if (req.mfg_valid && cid == CID_75) begin
			code_d = CLS_CO75;
		end else if (req.svc_valid && uuid == UUID_FE2C) begin
			code_d = CLS_SVC_FE2C;
		end else if (req.svc_valid && (uuid == UUID_FEED || uuid == UUID_FD84)) begin
			code_d = CLS_SVC_ALT;
		end
	end

	assign pop         = !qstat.empty && (!valid_q || class_ready);
	assign class_valid = valid_q;
	assign class_code  = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (class_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			code_q <= code_d;
	end

endmodule
